// ===== design/text_console_with_scroll_unit_defines.svh =====
// ============================================================================
// Text console assertion macros
// Assertion wrappers shared by the console RTL; define ASSERT_OFF to drop them.
// ============================================================================
`ifndef TEXT_CONSOLE_WITH_SCROLL_UNIT_DEFINES_SVH
`define TEXT_CONSOLE_WITH_SCROLL_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
`define TCSU_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define TCSU_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define TCSU_ASSERT(lbl, prop, msg)
`define TCSU_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== design/tcsu_pkg.sv =====
// ============================================================================
// Text console package
// Screen geometry, field widths and item kind codes.
// ============================================================================
package tcsu_pkg;

    localparam int COLUMNS = 70;
    localparam int ROWS    = 30;
    localparam int DEPTH   = ROWS * COLUMNS;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int ROW_W   = 5;
    localparam int COL_W   = 7;
    localparam int CHAR_W  = 8;
    localparam int KIND_W  = 3;

    localparam logic [KIND_W-1:0] K_PUT    = 3'd0;
    localparam logic [KIND_W-1:0] K_BACK   = 3'd1;
    localparam logic [KIND_W-1:0] K_SETCUR = 3'd2;
    localparam logic [KIND_W-1:0] K_SETROW = 3'd3;
    localparam logic [KIND_W-1:0] K_SETCOL = 3'd4;
    localparam logic [KIND_W-1:0] K_CLEAR  = 3'd5;
    localparam logic [KIND_W-1:0] K_READ   = 3'd6;

    localparam logic [CHAR_W-1:0] NEWLINE = 8'd10;

endpackage

// ===== design/text_console_with_scroll_unit.sv =====
// ============================================================================
// Text console with scroll
// Character-cell screen store with cursor, wrap, newline, scroll and readback.
// ============================================================================
// Usage:
//   Input channel i_in_valid / o_in_stall carries one command item (kind,
//   char_code, row, col). Output channel o_out_valid / i_out_stall returns
//   exactly one result item per command, in order.
//   The screen is one 2100 x 8 RAM. Scrolling rotates a row base pointer
//   instead of moving data, so only the vacated row is rewritten.
//   Read cell passes through S_READ for the registered RAM read; an item
//   that scrolls passes through S_ROW, zeroing the new bottom row; clear
//   passes through S_CLR, sweeping the RAM at one cell per cycle. No new
//   item is taken while any of these states is active.
//   The result is registered. The next item can be taken in the cycle the
//   waiting result leaves.
//   After reset the block sweeps the RAM to zero with o_in_stall high, then
//   starts with the cursor at row 0, column 0.
//   While i_out_stall is high the result holds and no further item is taken
//   once the output register is full.
// ============================================================================
`include "text_console_with_scroll_unit_defines.svh"

module text_console_with_scroll_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [tcsu_pkg::KIND_W-1:0]  i_kind,
    input  logic [tcsu_pkg::CHAR_W-1:0]  i_char_code,
    input  logic [tcsu_pkg::ROW_W-1:0]   i_row,
    input  logic [tcsu_pkg::COL_W-1:0]   i_col,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [tcsu_pkg::ROW_W-1:0]   o_cell_row,
    output logic [tcsu_pkg::COL_W-1:0]   o_cell_col,
    output logic [tcsu_pkg::CHAR_W-1:0]  o_cell_char,
    output logic                         o_cell_written,
    output logic                         o_scrolled,
    output logic [tcsu_pkg::ROW_W-1:0]   o_cursor_row_now,
    output logic [tcsu_pkg::COL_W-1:0]   o_cursor_col_now
);

    localparam int ROW_W  = tcsu_pkg::ROW_W;
    localparam int COL_W  = tcsu_pkg::COL_W;
    localparam int CHAR_W = tcsu_pkg::CHAR_W;
    localparam int ADDR_W = tcsu_pkg::ADDR_W;

    localparam logic [ROW_W-1:0]  LAST_ROW = ROW_W'(tcsu_pkg::ROWS - 1);
    localparam logic [COL_W-1:0]  LAST_COL = COL_W'(tcsu_pkg::COLUMNS - 1);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(tcsu_pkg::DEPTH - 1);
    localparam logic [ADDR_W-1:0] LAST_CNT_ROW = ADDR_W'(tcsu_pkg::COLUMNS - 1);

    localparam logic [1:0] S_CLR  = 2'd0;
    localparam logic [1:0] S_IDLE = 2'd1;
    localparam logic [1:0] S_READ = 2'd2;
    localparam logic [1:0] S_ROW  = 2'd3;

    function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] lrow,
                                                  input logic [ROW_W-1:0] base);
        logic [ROW_W:0] sum;
        sum = {1'b0, lrow} + {1'b0, base};
        if (sum >= (ROW_W+1)'(tcsu_pkg::ROWS)) begin
            sum = sum - (ROW_W+1)'(tcsu_pkg::ROWS);
        end
        return sum[ROW_W-1:0];
    endfunction

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] prow,
                                                    input logic [COL_W-1:0] col);
        return ADDR_W'(prow) * ADDR_W'(tcsu_pkg::COLUMNS) + ADDR_W'(col);
    endfunction

    logic [1:0]        r_state, n_state;
    logic [ADDR_W-1:0] r_cnt, n_cnt;
    logic [ADDR_W-1:0] r_clr_base, n_clr_base;
    logic [ROW_W-1:0]  r_base, n_base;
    logic [ROW_W-1:0]  r_cur_row, n_cur_row;
    logic [COL_W-1:0]  r_cur_col, n_cur_col;
    logic [ROW_W-1:0]  r_rd_row, n_rd_row;
    logic [COL_W-1:0]  r_rd_col, n_rd_col;
    logic              r_ovalid, n_ovalid;
    logic [ROW_W-1:0]  r_o_row, n_o_row;
    logic [COL_W-1:0]  r_o_col, n_o_col;
    logic [CHAR_W-1:0] r_o_char, n_o_char;
    logic              r_o_wr, n_o_wr;
    logic              r_o_scr, n_o_scr;
    logic [ROW_W-1:0]  r_o_crow, n_o_crow;
    logic [COL_W-1:0]  r_o_ccol, n_o_ccol;

    logic              w_out_free;
    logic              w_accept;
    logic              w_we;
    logic [ADDR_W-1:0] w_waddr;
    logic [CHAR_W-1:0] w_wdata;
    logic [ADDR_W-1:0] w_raddr;
    logic [CHAR_W-1:0] w_rdata;
    logic [ROW_W-1:0]  w_sat_row;
    logic [COL_W-1:0]  w_sat_col;
    logic [ROW_W-1:0]  w_cur_prow;
    logic [COL_W-1:0]  w_back_col;

    assign w_out_free = !r_ovalid || !i_out_stall;
    assign o_in_stall = !((r_state == S_IDLE) && w_out_free);
    assign w_accept   = i_in_valid && !o_in_stall;

    assign w_sat_row  = (i_row > LAST_ROW) ? LAST_ROW : i_row;
    assign w_sat_col  = (i_col > LAST_COL) ? LAST_COL : i_col;
    assign w_cur_prow = phys_row(r_cur_row, r_base);
    assign w_back_col = (r_cur_col != '0) ? r_cur_col - COL_W'(1) : r_cur_col;
    assign w_raddr    = cell_addr(phys_row(w_sat_row, r_base), w_sat_col);

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_clr_base = r_clr_base;
        n_base     = r_base;
        n_cur_row  = r_cur_row;
        n_cur_col  = r_cur_col;
        n_rd_row   = r_rd_row;
        n_rd_col   = r_rd_col;
        n_ovalid   = r_ovalid && i_out_stall;
        n_o_row    = r_o_row;
        n_o_col    = r_o_col;
        n_o_char   = r_o_char;
        n_o_wr     = r_o_wr;
        n_o_scr    = r_o_scr;
        n_o_crow   = r_o_crow;
        n_o_ccol   = r_o_ccol;
        w_we       = 1'b0;
        w_waddr    = cell_addr(w_cur_prow, r_cur_col);
        w_wdata    = '0;

        case (r_state)
            S_CLR: begin
                w_we    = 1'b1;
                w_waddr = r_cnt;
                n_cnt   = r_cnt + ADDR_W'(1);
                if (r_cnt == LAST_ADDR) begin
                    n_state = S_IDLE;
                end
            end
            S_ROW: begin
                w_we    = 1'b1;
                w_waddr = r_clr_base + r_cnt;
                n_cnt   = r_cnt + ADDR_W'(1);
                if (r_cnt == LAST_CNT_ROW) begin
                    n_state = S_IDLE;
                end
            end
            S_READ: begin
                n_ovalid = 1'b1;
                n_o_row  = r_rd_row;
                n_o_col  = r_rd_col;
                n_o_char = w_rdata;
                n_o_wr   = 1'b0;
                n_o_scr  = 1'b0;
                n_o_crow = r_cur_row;
                n_o_ccol = r_cur_col;
                n_state  = S_IDLE;
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_ovalid = 1'b1;
                    n_o_row  = '0;
                    n_o_col  = '0;
                    n_o_char = '0;
                    n_o_wr   = 1'b0;
                    n_o_scr  = 1'b0;
                    case (i_kind)
                        tcsu_pkg::K_PUT: begin
                            if (i_char_code != tcsu_pkg::NEWLINE) begin
                                w_we     = 1'b1;
                                w_wdata  = i_char_code;
                                n_o_row  = r_cur_row;
                                n_o_col  = r_cur_col;
                                n_o_char = i_char_code;
                                n_o_wr   = 1'b1;
                                n_cur_col = r_cur_col + COL_W'(1);
                            end
                            if (i_char_code == tcsu_pkg::NEWLINE ||
                                r_cur_col >= LAST_COL) begin
                                n_cur_col = '0;
                                if (r_cur_row >= LAST_ROW) begin
                                    n_o_scr    = 1'b1;
                                    n_cur_row  = LAST_ROW;
                                    n_base     = (r_base == LAST_ROW) ? '0
                                                                      : r_base + ROW_W'(1);
                                    n_clr_base = cell_addr(r_base, '0);
                                    n_cnt      = '0;
                                    n_state    = S_ROW;
                                end else begin
                                    n_cur_row = r_cur_row + ROW_W'(1);
                                end
                            end
                        end
                        tcsu_pkg::K_BACK: begin
                            w_we      = 1'b1;
                            w_waddr   = cell_addr(w_cur_prow, w_back_col);
                            n_cur_col = w_back_col;
                            n_o_row   = r_cur_row;
                            n_o_col   = w_back_col;
                            n_o_wr    = 1'b1;
                        end
                        tcsu_pkg::K_SETCUR: begin
                            n_cur_row = w_sat_row;
                            n_cur_col = w_sat_col;
                        end
                        tcsu_pkg::K_SETROW: begin
                            n_cur_row = w_sat_row;
                        end
                        tcsu_pkg::K_SETCOL: begin
                            n_cur_col = w_sat_col;
                        end
                        tcsu_pkg::K_CLEAR: begin
                            n_o_scr   = 1'b1;
                            n_cur_row = '0;
                            n_cur_col = '0;
                            n_base    = '0;
                            n_cnt     = '0;
                            n_state   = S_CLR;
                        end
                        tcsu_pkg::K_READ: begin
                            n_ovalid = 1'b0;
                            n_rd_row = w_sat_row;
                            n_rd_col = w_sat_col;
                            n_state  = S_READ;
                        end
                        default: begin
                        end
                    endcase
                    n_o_crow = n_cur_row;
                    n_o_ccol = n_cur_col;
                end
            end
            default: begin
                n_state = S_CLR;
                n_cnt   = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_cnt     <= '0;
            r_base    <= '0;
            r_cur_row <= '0;
            r_cur_col <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_base    <= n_base;
            r_cur_row <= n_cur_row;
            r_cur_col <= n_cur_col;
            r_ovalid  <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_clr_base <= n_clr_base;
        r_rd_row   <= n_rd_row;
        r_rd_col   <= n_rd_col;
        r_o_row    <= n_o_row;
        r_o_col    <= n_o_col;
        r_o_char   <= n_o_char;
        r_o_wr     <= n_o_wr;
        r_o_scr    <= n_o_scr;
        r_o_crow   <= n_o_crow;
        r_o_ccol   <= n_o_ccol;
    end

    tcsu_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (tcsu_pkg::DEPTH)
    ) u_screen (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign o_out_valid      = r_ovalid;
    assign o_cell_row       = r_o_row;
    assign o_cell_col       = r_o_col;
    assign o_cell_char      = r_o_char;
    assign o_cell_written   = r_o_wr;
    assign o_scrolled       = r_o_scr;
    assign o_cursor_row_now = r_o_crow;
    assign o_cursor_col_now = r_o_ccol;

    `TCSU_ASSERT(a_busy_stalls, (r_state != S_IDLE) |-> o_in_stall, "item taken while busy")
    `TCSU_ASSERT(a_cursor_range, (r_cur_row <= LAST_ROW) && (r_cur_col <= LAST_COL),
                 "cursor out of range")
    `TCSU_ASSERT(a_base_range, r_base <= LAST_ROW, "row base out of range")
    `TCSU_ASSERT_ALWAYS(a_waddr_range, w_we |-> (w_waddr <= LAST_ADDR),
                        "write address beyond screen")
    `TCSU_ASSERT(a_read_slot_free, (r_state == S_READ) |-> !r_ovalid,
                 "read result would overwrite a pending item")

endmodule

// ===== design/tcsu_ram.sv =====
// ============================================================================
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ============================================================================
module tcsu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
